// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file, pci_config_space_port.sv
// no dependencies; the macros expand to nothing in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/cfgsp_pkg.sv -----
// shared types, constants and tables of the configuration port
// no dependencies
`default_nettype none
package cfgsp_pkg;
    localparam int DEV_COUNT = 3;
    localparam int CFG_BYTES = 256;           // power of two, offsets wrap by mask
    localparam int OFF_W     = $clog2(CFG_BYTES);
    localparam int DEV_W     = (DEV_COUNT > 1) ? $clog2(DEV_COUNT) : 1;
    localparam int MEM_DEPTH = DEV_COUNT * CFG_BYTES;
    localparam int MEM_AW    = DEV_W + OFF_W;

    localparam logic [2:0] PORT_ADDR  = 3'd0;
    localparam logic [2:0] PORT_UNDEF = 3'd1;
    localparam logic [2:0] PORT_RSV2  = 3'd2;
    localparam logic [2:0] PORT_RSV3  = 3'd3;
    localparam logic       MODE_READ  = 1'b0;
    localparam logic       MODE_WRITE = 1'b1;
    localparam logic [7:0] OFF_HDR    = 8'h0e;

    typedef struct packed {
        logic clr;
        logic take;
        logic imm;
        logic hdr_rd;
        logic hdr_cap;
        logic wr_byte;
        logic rd_issue;
        logic rd_cap;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic imm;
        logic is_wr;
        logic last_byte;
    } t_status;

    function automatic logic [31:0] width_mask(input logic [2:0] size);
        logic [31:0] m;
        unique case (size)
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    function automatic logic writable(input logic [7:0] off, input logic std_hdr);
        logic ro;
        ro = (off <= 8'h03) || (off >= 8'h08 && off <= 8'h0b) || off == 8'h0e ||
             off == 8'h3d;
        if (std_hdr)
            ro = ro || (off >= 8'h10 && off <= 8'h27) || (off >= 8'h30 && off <= 8'h33);
        else
            ro = ro || (off >= 8'h38 && off <= 8'h3b);
        return !ro;
    endfunction

    // power-up image: device in upper address bits, byte offset below
    function automatic logic [7:0] init_byte(input logic [MEM_AW-1:0] a);
        logic [7:0] v;
        logic [DEV_W-1:0] d;
        logic [OFF_W-1:0] o;
        d = a[MEM_AW-1:OFF_W];
        o = a[OFF_W-1:0];
        v = 8'h00;
        if (32'(d) == 0) begin
            priority case (o)
                8'h00: v = 8'h86;  8'h01: v = 8'h80;  8'h02: v = 8'h37;
                8'h03: v = 8'h12;  8'h08: v = 8'h02;  8'h0b: v = 8'h06;
                default: v = 8'h00;
            endcase
        end else if (32'(d) == 1) begin
            priority case (o)
                8'h00: v = 8'h86;  8'h01: v = 8'h80;  8'h02: v = 8'h10;
                8'h03: v = 8'h70;  8'h0a: v = 8'h01;  8'h0b: v = 8'h01;
                8'h41: v = 8'h80;  8'h43: v = 8'h80;  8'h20: v = 8'h01;
                8'h21: v = 8'hc0;  8'h04: v = 8'h01;
                default: v = 8'h00;
            endcase
        end else if (32'(d) == 2) begin
            priority case (o)
                8'h00: v = 8'h86;  8'h01: v = 8'h80;  8'h03: v = 8'h70;
                8'h0a: v = 8'h01;  8'h0b: v = 8'h06;  8'h0e: v = 8'h80;
                8'h04: v = 8'h07;  8'h07: v = 8'h02;  8'h4c: v = 8'h4d;
                8'h4e: v = 8'h03;  8'h60: v = 8'h80;  8'h69: v = 8'h02;
                8'h70: v = 8'h80;  8'h76: v = 8'h0c;  8'h77: v = 8'h0c;
                8'h78: v = 8'h02;  8'ha0: v = 8'h08;  8'ha8: v = 8'h0f;
                default: v = 8'h00;
            endcase
        end
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/pci_config_space_port.sv -----
// top level of the configuration port: sequencer plus datapath
// depends on cfgsp_pkg, cfgsp_ctrl, cfgsp_dp and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
// Host bridge configuration port (mechanism 1). One input transfer is one port
// access at 0xcf8..0xcff; one result transfer comes back for each. After reset
// the block sweeps its 768-byte store, one byte a cycle, writing the power-up
// identity images (o_ready low). The store has a single port, so data
// accesses go one byte at a time: address port, reserved, invalid and
// out-of-range accesses go from decode straight to the result register; a
// valid data read issues and captures each byte in turn; a valid data write
// fetches the header type, then writes one byte per cycle. The sequencer
// returns to idle after each result before the next transfer is taken; an
// access is held up only while a full result register waits on o_valid
// without i_ready.
// The next access is taken while the previous result waits in the output
// register.
module pci_config_space_port (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_mode,
    input  wire logic [2:0]  i_port_offset,
    input  wire logic [2:0]  i_size,
    input  wire logic [31:0] i_write_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_rd_value,
    output logic             o_bad_access
);
    import cfgsp_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: owns state and result valid
    cfgsp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath: address register, store and result register
    cfgsp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (i_mode),
        .i_port_offset (i_port_offset),
        .i_size        (i_size),
        .i_write_data  (i_write_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_rd_value    (o_rd_value),
        .o_bad_access  (o_bad_access)
    );

    // one access in flight: no new transfer right after one is taken
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // result register only loaded when free or being drained
    `ASSERT_IMPL(a_out_free, i_clk, i_rst_n, cmd.out_load, !o_valid || i_ready)
    // at most one store operation per cycle
    `ASSERT_IMPL(a_mem_one, i_clk, i_rst_n, 1'b1,
        $onehot0({cmd.clr, cmd.hdr_rd, cmd.wr_byte, cmd.rd_issue}))
endmodule
`default_nettype wire

// ----- rtl/cfgsp_ctrl.sv -----
// sequencer of the configuration port: clear sweep, decode, byte steps, result
// depends on cfgsp_pkg
`default_nettype none
module cfgsp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_ready,
    input  wire cfgsp_pkg::t_status i_status,
    output cfgsp_pkg::t_cmd       o_cmd
);
    import cfgsp_pkg::*;

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_DEC  = 9'b000000100,
        S_HDR  = 9'b000001000,
        S_HCAP = 9'b000010000,
        S_WR   = 9'b000100000,
        S_RISS = 9'b001000000,
        S_RCAP = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_status.imm) begin
                    o_cmd.imm = 1'b1;
                    n_state   = S_DONE;
                end else if (i_status.is_wr) begin
                    n_state = S_HDR;
                end else begin
                    n_state = S_RISS;
                end
            end
            S_HDR: begin
                o_cmd.hdr_rd = 1'b1;
                n_state      = S_HCAP;
            end
            S_HCAP: begin
                o_cmd.hdr_cap = 1'b1;
                n_state       = S_WR;
            end
            S_WR: begin
                o_cmd.wr_byte = 1'b1;
                if (i_status.last_byte) n_state = S_DONE;
            end
            S_RISS: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RCAP;
            end
            S_RCAP: begin
                o_cmd.rd_cap = 1'b1;
                n_state      = i_status.last_byte ? S_DONE : S_RISS;
            end
            S_DONE: begin
                if (!r_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_cmd.out_load)       n_valid = 1'b1;
        else if (r_valid && i_ready) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
endmodule
`default_nettype wire

// ----- rtl/cfgsp_dp.sv -----
// datapath: address register, byte store, decode, byte assembly, result register
// depends on cfgsp_pkg
`default_nettype none
module cfgsp_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_mode,
    input  wire logic [2:0]    i_port_offset,
    input  wire logic [2:0]    i_size,
    input  wire logic [31:0]   i_write_data,
    input  wire cfgsp_pkg::t_cmd i_cmd,
    output cfgsp_pkg::t_status o_status,
    output logic [31:0]        o_rd_value,
    output logic               o_bad_access
);
    import cfgsp_pkg::*;

    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        r_rdata;
    logic [MEM_AW-1:0] r_clr;
    logic [31:0]       r_addr;
    logic              r_mode;
    logic [2:0]        r_port, r_size;
    logic [31:0]       r_wdata;
    logic [1:0]        r_cnt;
    logic [31:0]       r_rd;
    logic              r_bad;
    logic              r_std;
    logic [31:0]       r_out_rd;
    logic              r_out_bad;

    logic              size_ok, dec_ok, bar4;
    logic [4:0]        dev;
    logic [7:0]        off, boff;
    logic [31:0]       mask, wval;
    logic [MEM_AW-1:0] maddr;
    logic              we;
    logic [7:0]        wbyte;

    always_comb begin
        size_ok = (r_size >= 3'd1) && (r_size <= 3'd4);
        dev     = r_addr[15:11];
        off     = {r_addr[7:2], r_port[1:0]};
        boff    = off + {6'd0, r_cnt};
        dec_ok  = r_addr[31] && (r_addr[1:0] == 2'd0) && (r_addr[23:16] == 8'd0) &&
                  (r_addr[10:8] == 3'd0) && (32'(dev) < DEV_COUNT);
        mask    = width_mask(r_size);
        bar4    = (r_size == 3'd4) && (off >= 8'h20) && (off <= 8'h23);
        wval    = bar4 ? {r_wdata[31:4], 4'b0001} : r_wdata;
        wbyte   = wval[{r_cnt, 3'b000} +: 8];

        o_status.clr_last  = (32'(r_clr) == MEM_DEPTH - 1);
        o_status.imm       = !size_ok || !r_port[2] || !dec_ok;
        o_status.is_wr     = (r_mode == MODE_WRITE);
        o_status.last_byte = ({1'b0, r_cnt} == r_size - 3'd1);

        we    = 1'b0;
        maddr = {dev[DEV_W-1:0], boff[OFF_W-1:0]};
        if (i_cmd.clr) begin
            we    = 1'b1;
            maddr = r_clr;
        end else if (i_cmd.hdr_rd) begin
            maddr = {dev[DEV_W-1:0], OFF_HDR[OFF_W-1:0]};
        end else if (i_cmd.wr_byte) begin
            we = bar4 || writable(boff, r_std);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[maddr] <= i_cmd.clr ? init_byte(r_clr) : wbyte;
        r_rdata <= mem[maddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_addr <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.imm && r_mode == MODE_WRITE && size_ok && r_port == PORT_ADDR)
                r_addr <= (r_addr & ~mask) | (r_wdata & mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mode  <= i_mode;
            r_port  <= i_port_offset;
            r_size  <= i_size;
            r_wdata <= i_write_data;
            r_cnt   <= 2'd0;
            r_rd    <= '0;
            r_bad   <= 1'b0;
        end
        if (i_cmd.imm) begin
            if (!size_ok || r_port == PORT_UNDEF) begin
                r_rd  <= '0;
                r_bad <= 1'b1;
            end else if (r_mode == MODE_READ) begin
                priority if (r_port == PORT_ADDR) begin
                    r_rd  <= r_addr & mask;
                    r_bad <= 1'b0;
                end else if (r_port == PORT_RSV3) begin
                    r_rd  <= '0;
                    r_bad <= 1'b1;
                end else if (r_port[2]) begin
                    r_rd  <= mask;
                    r_bad <= (r_size == 3'd3);
                end else begin
                    r_rd  <= '0;
                    r_bad <= 1'b0;
                end
            end else begin
                r_rd  <= '0;
                r_bad <= 1'b0;
            end
        end
        if (i_cmd.hdr_cap) r_std <= (r_rdata == 8'h00) || (r_rdata == 8'h80);
        if (i_cmd.wr_byte) r_cnt <= r_cnt + 2'd1;
        if (i_cmd.rd_cap) begin
            r_rd[{r_cnt, 3'b000} +: 8] <= r_rdata;
            r_cnt <= r_cnt + 2'd1;
        end
        if (i_cmd.out_load) begin
            r_out_rd  <= r_rd;
            r_out_bad <= r_bad;
        end
    end

    assign o_rd_value   = r_out_rd;
    assign o_bad_access = r_out_bad;
endmodule
`default_nettype wire
